### hdl/htc_pkg.sv
// htc_pkg: fixed-point constants, widths and shared types for the
// humidity/temperature compensation pipeline; no dependencies
package htc_pkg;

  localparam int FRAC_BITS = 24;

  localparam int H_W    = 12;
  localparam int T_W    = 14;
  localparam int TC_W   = 15;
  localparam int HUM_W  = 14;
  localparam int HH_W   = 2 * H_W;
  localparam int K_W    = FRAC_BITS;
  localparam int LIN_W  = FRAC_BITS + 9;
  localparam int PROD_W = LIN_W - 1;
  localparam int SLP_W  = FRAC_BITS;
  localparam int DM_W   = TC_W + SLP_W + 1;
  localparam int SUM_W  = FRAC_BITS + 16;
  localparam int RND_W  = SUM_W - FRAC_BITS;

  localparam longint K2_L  = ((longint'(405) << FRAC_BITS) + 5000) / 10000;
  localparam longint K3_L  = ((longint'(28) << FRAC_BITS) + 5000000) / 10000000;
  localparam longint KT1_L = ((longint'(1) << FRAC_BITS) + 50) / 100;
  localparam longint KT2_L = ((longint'(8) << FRAC_BITS) + 50000) / 100000;

  localparam logic [K_W-1:0] K2  = K_W'(K2_L);
  localparam logic [K_W-1:0] K3  = K_W'(K3_L);
  localparam logic [K_W-1:0] KT1 = K_W'(KT1_L);
  localparam logic [K_W-1:0] KT2 = K_W'(KT2_L);

  localparam logic signed [LIN_W-1:0] C1   = LIN_W'(-(longint'(4) << FRAC_BITS));
  localparam logic signed [SUM_W-1:0] HALF = SUM_W'(longint'(1) << (FRAC_BITS - 1));
  localparam logic signed [7:0]       HUNDRED = 8'sd100;

  localparam logic signed [TC_W-1:0]  TEMP_OFFSET = 15'sd3960;
  localparam logic signed [TC_W-1:0]  TEMP_REF    = 15'sd6460;
  localparam logic signed [RND_W-1:0] HUM_TOP     = RND_W'(10000);
  localparam logic signed [RND_W-1:0] HUM_BOTTOM  = RND_W'(10);

  typedef enum logic [1:0] {
    CLAMP_NONE   = 2'd0,
    CLAMP_TOP    = 2'd1,
    CLAMP_BOTTOM = 2'd2
  } clamp_t;

  typedef struct packed {
    logic                    valid;
    logic signed [LIN_W-1:0] lin;
    logic [SLP_W-1:0]        slope;
    logic signed [TC_W-1:0]  delta;
    logic signed [TC_W-1:0]  temp;
  } lin_bus_t;

endpackage

### hdl/htc_lin.sv
// htc_lin: stages 1-3, square of the humidity count, coefficient products,
// linearised humidity and compensation slope; depends on htc_pkg
module htc_lin (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [htc_pkg::H_W-1:0]     humidity_ticks,
  input  logic [htc_pkg::T_W-1:0]     temperature_ticks,
  output htc_pkg::lin_bus_t           lin_bus
);
  import htc_pkg::*;

  logic                    v1_r, v2_r, v3_r;
  logic [H_W-1:0]          h1_r;
  logic [HH_W-1:0]         hh1_r;
  logic signed [TC_W-1:0]  temp1_r, temp2_r, temp3_r;
  logic signed [TC_W-1:0]  d1_r, d2_r, d3_r;
  logic [PROD_W-1:0]       k2h2_r, k3hh2_r;
  logic [SLP_W-1:0]        kth2_r;
  logic signed [LIN_W-1:0] lin3_r;
  logic [SLP_W-1:0]        slope3_r;

  logic signed [TC_W-1:0]  t_s;
  logic [K_W+H_W-1:0]      k2h_full, kth_full;
  logic [K_W+HH_W-1:0]     k3hh_full;
  logic signed [LIN_W-1:0] lin_nxt;
  logic [SLP_W-1:0]        slope_nxt;

  assign t_s       = $signed({1'b0, temperature_ticks});
  assign k2h_full  = K2 * h1_r;
  assign k3hh_full = K3 * hh1_r;
  assign kth_full  = KT2 * h1_r;
  assign lin_nxt   = C1 + $signed({1'b0, k2h2_r}) - $signed({1'b0, k3hh2_r});
  assign slope_nxt = KT1 + kth2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= start;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    h1_r     <= humidity_ticks;
    hh1_r    <= humidity_ticks * humidity_ticks;
    temp1_r  <= t_s - TEMP_OFFSET;
    d1_r     <= t_s - TEMP_REF;
    k2h2_r   <= k2h_full[PROD_W-1:0];
    k3hh2_r  <= k3hh_full[PROD_W-1:0];
    kth2_r   <= kth_full[SLP_W-1:0];
    temp2_r  <= temp1_r;
    d2_r     <= d1_r;
    lin3_r   <= lin_nxt;
    slope3_r <= slope_nxt;
    temp3_r  <= temp2_r;
    d3_r     <= d2_r;
  end

  assign lin_bus.valid = v3_r;
  assign lin_bus.lin   = lin3_r;
  assign lin_bus.slope = slope3_r;
  assign lin_bus.delta = d3_r;
  assign lin_bus.temp  = temp3_r;

endmodule

### hdl/htc_out.sv
// htc_out: stages 4-5, temperature correction product, rounding and clamp;
// depends on htc_pkg
module htc_out (
  input  logic                          clk,
  input  logic                          rst_n,
  input  htc_pkg::lin_bus_t             lin_bus,
  output logic                          out_valid,
  output logic signed [htc_pkg::TC_W-1:0] out_temperature_centi,
  output logic [htc_pkg::HUM_W-1:0]     out_humidity_centi,
  output htc_pkg::clamp_t               out_clamp_state
);
  import htc_pkg::*;

  logic                    v4_r, v5_r;
  logic signed [SUM_W-1:0] lin100_r;
  logic signed [DM_W-1:0]  dmul_r;
  logic signed [TC_W-1:0]  temp4_r, temp5_r;
  logic [HUM_W-1:0]        hum5_r;
  clamp_t                  clamp5_r;

  logic signed [SUM_W-1:0] lin100_nxt;
  logic signed [DM_W-1:0]  dmul_nxt;
  logic signed [SUM_W-1:0] sum;
  logic signed [RND_W-1:0] hum_rnd;
  logic [HUM_W-1:0]        hum_nxt;
  clamp_t                  clamp_nxt;

  assign lin100_nxt = lin_bus.lin * HUNDRED;
  assign dmul_nxt   = lin_bus.delta * $signed({1'b0, lin_bus.slope});
  assign sum        = lin100_r + SUM_W'(dmul_r) + HALF;
  assign hum_rnd    = sum[SUM_W-1:FRAC_BITS];

  always_comb begin
    if (hum_rnd > HUM_TOP) begin
      hum_nxt   = HUM_W'(HUM_TOP);
      clamp_nxt = CLAMP_TOP;
    end else if (hum_rnd < HUM_BOTTOM) begin
      hum_nxt   = HUM_W'(HUM_BOTTOM);
      clamp_nxt = CLAMP_BOTTOM;
    end else begin
      hum_nxt   = hum_rnd[HUM_W-1:0];
      clamp_nxt = CLAMP_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      v4_r <= lin_bus.valid;
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    lin100_r <= lin100_nxt;
    dmul_r   <= dmul_nxt;
    temp4_r  <= lin_bus.temp;
    temp5_r  <= temp4_r;
    hum5_r   <= hum_nxt;
    clamp5_r <= clamp_nxt;
  end

  assign out_valid             = v5_r;
  assign out_temperature_centi = temp5_r;
  assign out_humidity_centi    = hum5_r;
  assign out_clamp_state       = clamp5_r;

endmodule

### hdl/humidity_temp_compensation.sv
// humidity_temp_compensation: top level, five-stage pipeline from a raw
// humidity/temperature request to temperature and compensated humidity
// start passes down a chain of valid registers to out_valid, one request per cycle, busy stays low
// the multiplies sit in stages 1, 2 and 4, the wide adds and the compare in stages 3 and 5
// synchronous active-low reset clears the valid bits; data registers are not reset
// results are strobed for one cycle and cannot be held off by the receiver
module humidity_temp_compensation (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [htc_pkg::H_W-1:0]         in_humidity_ticks,
  input  logic [htc_pkg::T_W-1:0]         in_temperature_ticks,
  output logic                            out_valid,
  output logic signed [htc_pkg::TC_W-1:0] out_temperature_centi,
  output logic [htc_pkg::HUM_W-1:0]       out_humidity_centi,
  output htc_pkg::clamp_t                 out_clamp_state
);
  import htc_pkg::*;

  lin_bus_t lin_bus;

  assign busy = 1'b0;

  htc_lin u_lin (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .humidity_ticks    (in_humidity_ticks),
    .temperature_ticks (in_temperature_ticks),
    .lin_bus           (lin_bus)
  );

  htc_out u_out (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .lin_bus               (lin_bus),
    .out_valid             (out_valid),
    .out_temperature_centi (out_temperature_centi),
    .out_humidity_centi    (out_humidity_centi),
    .out_clamp_state       (out_clamp_state)
  );

  a_valid_follows_start: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, 5))
    else $error("result strobe without a request five cycles earlier");

  a_hum_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_humidity_centi >= 14'd10 && out_humidity_centi <= 14'd10000))
    else $error("humidity outside clamp range");

  a_clamp_value: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_clamp_state != CLAMP_NONE) |->
      ((out_clamp_state == CLAMP_TOP && out_humidity_centi == 14'd10000) ||
       (out_clamp_state == CLAMP_BOTTOM && out_humidity_centi == 14'd10)))
    else $error("clamp flag disagrees with humidity");

  a_temp_path: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_temperature_centi ==
      $signed({1'b0, $past(in_temperature_ticks, 5)}) - TEMP_OFFSET)
    else $error("temperature does not match request");

endmodule
